@@ sv/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

   // fixed field widths
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int SLOT_IDX_W = 8;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 2;

   // default table depth
   localparam int DEPTH_DEF = 256;

   // remainder unit: quotient bits retired per cycle
   localparam int DIGIT_BITS = 4;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CFG_W      = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_POLICY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKETS_IN_USE = 8'd1;

   localparam logic [CFG_W-1:0] BUCKETS_RST = 9'd256;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   // slot states
   localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_LIVE  = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_GONE  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
      logic [VALUE_W-1:0]      new_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [VALUE_W-1:0]    found_value;
      logic [SLOT_IDX_W-1:0] slot_index;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic load_home;
      logic read;
      logic commit;
      logic advance;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic hit_done;
      logic walk_last;
   } stat_type;

endpackage

`default_nettype wire

@@ sv/lpht_div.sv @@
`default_nettype none

module lpht_div
   import lpht_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [KEY_W-1:0]                dividend,
   input  wire logic [$clog2(DEPTH+1)-1:0]      divisor,
   output logic                                 done,
   output logic [$clog2(DEPTH+1)-1:0]           remainder
);

   localparam int REM_W  = $clog2(DEPTH+1);
   localparam int STEPS  = KEY_W / DIGIT_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [KEY_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  dsr_ff, dsr_in;

   logic [REM_W-1:0]  rem_v;
   logic [KEY_W-1:0]  dvd_v;
   logic [REM_W:0]    trial;
   logic              last_step;

   // restoring remainder, several quotient bits a cycle
   always_comb begin
      rem_v = rem_ff;
      dvd_v = dvd_ff;
      trial = '0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         trial = {rem_v, dvd_v[KEY_W-1]};
         dvd_v = {dvd_v[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_v = REM_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_v = trial[REM_W-1:0];
         end
      end
   end

   assign last_step = (step_ff == STEP_W'(STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         rem_in  = rem_v;
         dvd_in  = dvd_v;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

endmodule

`default_nettype wire

@@ sv/lpht_dp.sv @@
`default_nettype none

module lpht_dp
   import lpht_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire req_type               req_data,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int NW     = $clog2(DEPTH+1);
   localparam int WIDE_W = (NW > CFG_W) ? NW : CFG_W;

   // configuration
   logic              policy_ff, policy_in;
   logic [CFG_W-1:0]  buckets_ff, buckets_in;

   // request and walk state
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               neg_ff, neg_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]   loc_ff, loc_in;
   logic [NW-1:0]      count_ff, count_in;

   // result and output
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [VALUE_W-1:0]    res_found_ff, res_found_in;
   logic [SLOT_IDX_W-1:0] res_slot_ff, res_slot_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // memories and registered read data
   logic [SLOT_W-1:0]  status_mem [DEPTH];
   logic [KEY_W-1:0]   key_mem    [DEPTH];
   logic [VALUE_W-1:0] value_mem  [DEPTH];
   logic [SLOT_W-1:0]  rd_status_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   logic [WIDE_W-1:0]  b_wide, n_wide;
   logic [NW-1:0]      n_active;
   logic [KEY_W-1:0]   req_key_bits, mag;
   logic [NW-1:0]      rem;
   logic               div_done;
   logic [NW-1:0]      home;
   logic [NW-1:0]      loc_next;

   logic               live, match;
   logic               ev_done, ev_hit, ev_st_we, ev_key_we, ev_val_we;
   logic [STATUS_W-1:0] ev_status;
   logic [VALUE_W-1:0]  ev_found;
   logic [SLOT_W-1:0]   ev_st_wdata;

   logic               st_we;
   logic [IDX_W-1:0]   st_waddr;
   logic [SLOT_W-1:0]  st_wdata;

   logic               clear_last, walk_last;

   // config writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      policy_in  = policy_ff;
      buckets_in = buckets_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INSERT_POLICY:  policy_in  = csr_data[0];
            CSR_BUCKETS_IN_USE: buckets_in = csr_data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // bucket count clamped to 1..DEPTH
   always_comb begin
      b_wide = WIDE_W'(buckets_ff);
      if (b_wide == '0) begin
         n_wide = WIDE_W'(1);
      end else if (b_wide > WIDE_W'(DEPTH)) begin
         n_wide = WIDE_W'(DEPTH);
      end else begin
         n_wide = b_wide;
      end
      n_active = n_wide[NW-1:0];
   end

   assign req_key_bits = req_data.key;
   assign mag = req_key_bits[KEY_W-1] ? (~req_key_bits + KEY_W'(1)) : req_key_bits;

   lpht_div #(
      .DEPTH(DEPTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_req),
      .dividend  (mag),
      .divisor   (n_active),
      .done      (div_done),
      .remainder (rem)
   );

   // non-negative remainder for negative keys
   assign home = (neg_ff && (rem != '0)) ? (n_ff - rem) : rem;

   assign loc_next = NW'(loc_ff) + NW'(1);

   // probe decision on the slot just read
   always_comb begin
      live        = (rd_status_ff == SLOT_LIVE);
      match       = live && (rd_key_ff == key_ff);
      ev_done     = 1'b0;
      ev_hit      = 1'b0;
      ev_status   = res_status_ff;
      ev_found    = '0;
      ev_st_we    = 1'b0;
      ev_st_wdata = SLOT_LIVE;
      ev_key_we   = 1'b0;
      ev_val_we   = 1'b0;
      if ((mode_ff == MODE_INSERT) || (mode_ff == MODE_UPDATE)) begin
         if (match) begin
            ev_done = 1'b1;
            if ((mode_ff == MODE_INSERT) && !policy_ff) begin
               ev_status = ST_DUP;
            end else begin
               ev_val_we = 1'b1;
               ev_status = ST_OK;
               ev_hit    = 1'b1;
            end
         end else if (!live) begin
            ev_done   = 1'b1;
            ev_st_we  = 1'b1;
            ev_key_we = 1'b1;
            ev_val_we = 1'b1;
            ev_status = ST_OK;
            ev_hit    = 1'b1;
         end
      end else begin
         if (rd_status_ff == SLOT_EMPTY) begin
            ev_done = 1'b1;
         end else if (match) begin
            ev_done   = 1'b1;
            ev_status = ST_OK;
            ev_hit    = 1'b1;
            if (mode_ff == MODE_DELETE) begin
               ev_st_we    = 1'b1;
               ev_st_wdata = SLOT_GONE;
            end else begin
               ev_found = rd_value_ff;
            end
         end
      end
   end

   always_comb begin
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      neg_in        = neg_ff;
      n_in          = n_ff;
      loc_in        = loc_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      rsp_data_in   = rsp_data_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.load_req) begin
         mode_in       = req_data.mode;
         key_in        = req_key_bits;
         value_in      = req_data.new_value;
         neg_in        = req_key_bits[KEY_W-1];
         n_in          = n_active;
         res_status_in = (req_data.mode == MODE_INSERT || req_data.mode == MODE_UPDATE)
                         ? ST_FULL : ST_MISSING;
         res_found_in  = '0;
         res_slot_in   = '0;
      end
      if (cmd.load_home) begin
         loc_in   = home[IDX_W-1:0];
         count_in = '0;
      end
      if (cmd.advance) begin
         loc_in   = (loc_next >= n_ff) ? '0 : loc_next[IDX_W-1:0];
         count_in = count_ff + NW'(1);
      end
      if (cmd.commit) begin
         res_status_in = ev_status;
         res_found_in  = ev_found;
         res_slot_in   = ev_hit ? SLOT_IDX_W'(loc_ff) : '0;
      end
      if (cmd.load_rsp) begin
         rsp_data_in.status      = res_status_ff;
         rsp_data_in.found_value = res_found_ff;
         rsp_data_in.slot_index  = res_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= 1'b0;
         buckets_ff <= BUCKETS_RST;
         clr_ff     <= '0;
      end else begin
         policy_ff  <= policy_in;
         buckets_ff <= buckets_in;
         clr_ff     <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      neg_ff        <= neg_in;
      n_ff          <= n_in;
      loc_ff        <= loc_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // status memory shared by the clearing pass and the walk
   assign st_we    = cmd.clear_step || (cmd.commit && ev_st_we);
   assign st_waddr = cmd.clear_step ? clr_ff : loc_ff;
   assign st_wdata = cmd.clear_step ? SLOT_EMPTY : ev_st_wdata;

   always_ff @(posedge clock) begin
      if (st_we) begin
         status_mem[st_waddr] <= st_wdata;
      end
      if (cmd.read) begin
         rd_status_ff <= status_mem[loc_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ev_key_we) begin
         key_mem[loc_ff] <= key_ff;
      end
      if (cmd.read) begin
         rd_key_ff <= key_mem[loc_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ev_val_we) begin
         value_mem[loc_ff] <= value_ff;
      end
      if (cmd.read) begin
         rd_value_ff <= value_mem[loc_ff];
      end
   end

   assign clear_last = (clr_ff == IDX_W'(DEPTH - 1));
   assign walk_last  = ((count_ff + NW'(1)) == n_ff);

   // status word in field order: clear_last, div_done, hit_done, walk_last
   assign stat = {clear_last, div_done, ev_done, walk_last};

   assign rsp_data = rsp_data_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> ((NW'(loc_ff) < n_ff) && (count_ff < n_ff)))
      else $error("probe outside buckets in use");

endmodule

`default_nettype wire

@@ sv/lpht_ctrl.sv @@
`default_nettype none

module lpht_ctrl
   import lpht_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output cmd_type       cmd,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_EVAL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.load_home = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.hit_done) begin
               cmd.commit = 1'b1;
               state_in   = S_FINISH;
            end else if (stat.walk_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ($past(state_ff) == S_READ))
      else $error("evaluation without a slot read");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised outside finish");

endmodule

`default_nettype wire

@@ sv/linear_probe_hash_table_unit.sv @@
`default_nettype none

// key/value table with open addressing and linear probing over up to DEPTH
// buckets. after reset a clearing pass marks every slot empty, one slot a
// cycle; requests wait until it ends, configuration writes are taken at any
// time (csr_ready is always high) but only belong while the table is idle.
// each request transfer computes the home bucket as the non-negative
// remainder of the key by buckets_in_use in an iterative remainder unit that
// retires four quotient bits a cycle, then walks the buckets one at a time
// (registered memory read, then compare and write back). the finished
// response sits in an output register, so the next request transfer is taken
// while the response still waits for rsp_ready. deleted slots stay behind as
// tombstones and are reused by insert/update

module linear_probe_hash_table_unit
   import lpht_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,

   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,

   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: clearing pass, remainder wait, probe loop, response hand-off
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // datapath: config registers, remainder unit, slot memories, result regs
   lpht_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire
